/* rtl/core/wrsi_pkg.sv */
// ----------------------------------------------------------------------------
// wrsi_pkg
// Shared types and constants for the Wilder RSI block.
// ----------------------------------------------------------------------------
package wrsi_pkg;

   // default parameter values for the top level
   localparam int PRICE_BITS_DEF     = 32;
   localparam int AVG_FRAC_BITS_DEF  = 16;

   // gain / loss store width (sums during warm-up, averages after)
   localparam int STORE_BITS         = 48;

   // smoothing period register
   localparam int PERIOD_BITS        = 8;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;

   // difference count value that marks the averages as warm
   localparam logic [PERIOD_BITS-1:0] WARM_MARK    = 8'hFF;

   // RSI output, Q7.16; full scale 100.0 = 25 << 18
   localparam int RSI_BITS           = 23;
   localparam logic [RSI_BITS-1:0] RSI_FULL = 23'd6553600;
   localparam logic [PERIOD_BITS-1:0] RSI_SCALE = 8'd25;
   localparam int RSI_SHIFT          = 18;
   localparam int RSI_PRE_BITS       = RSI_BITS - RSI_SHIFT;

   // smoothing numerator is kept modulo 2^64
   localparam int NUM_WRAP_BITS      = 64;

   // serial units
   localparam int MUL_BITS           = STORE_BITS + PERIOD_BITS;
   localparam int DEN_BITS           = STORE_BITS + 1;
   localparam int REM_BITS           = DEN_BITS + 1;
   localparam int DIV_CNT_BITS       = $clog2(STORE_BITS);

   // configuration port
   localparam int CSR_ADDR_BITS      = 2;
   localparam int CSR_DATA_BITS      = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PERIOD_ADDR = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_GAIN,
      ST_DIV_GAIN,
      ST_MUL_LOSS,
      ST_DIV_LOSS,
      ST_MUL_RSI,
      ST_DIV_RSI,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

/* rtl/core/wrsi_if.sv */
// ----------------------------------------------------------------------------
// wrsi_req_if / wrsi_rsp_if
// Valid/ready channels for price transactions in and RSI transactions out.
// ----------------------------------------------------------------------------
interface wrsi_req_if #(
   parameter int PRICE_BITS = wrsi_pkg::PRICE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] price;
   logic                  first_of_series;

   modport source (output valid, output price, output first_of_series, input ready);
   modport sink   (input valid, input price, input first_of_series, output ready);
endinterface

interface wrsi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wrsi_pkg::RSI_BITS-1:0] rsi;

   modport source (output valid, output rsi, input ready);
   modport sink   (input valid, input rsi, output ready);
endinterface

/* rtl/core/wilder_relative_strength_index.sv */
// ----------------------------------------------------------------------------
// wilder_relative_strength_index
// Wilder RSI over a stream of unsigned Q16.16 prices, bit-serial datapath.
// ----------------------------------------------------------------------------
// Takes one price transaction at a time and returns an RSI transaction
// (Q7.16, 0 to 100) once the averages are warm. A warm item takes one 8-step
// shift-and-add multiply and one 48-step restoring division for each of the
// two averages, then an 8-step multiply and a 23-step division for the ratio,
// all on one multiplier and one divider that retire a bit per cycle. The item
// that completes warm-up skips the two averaging multiplies; a warm-up item
// without a result only passes through the difference state, and a restart
// item is handled in the idle state. An average that saturates skips its
// division, and a zero average loss skips the ratio. A finished result sits
// in the output register, so the next transaction is accepted while it
// waits. period is at byte address 0 of the APB port; period 0 acts as 1.
// ----------------------------------------------------------------------------
module wilder_relative_strength_index #(
   parameter int PRICE_BITS            = wrsi_pkg::PRICE_BITS_DEF,
   parameter int AVERAGE_FRACTION_BITS = wrsi_pkg::AVG_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wrsi_req_if.sink                             req_ch,
   wrsi_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wrsi_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wrsi_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wrsi_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int SB     = wrsi_pkg::STORE_BITS;
   localparam int PB     = wrsi_pkg::PERIOD_BITS;
   localparam int F      = AVERAGE_FRACTION_BITS;
   // numerator of an average: avg*(p-1) + (fresh << F), with headroom
   localparam int NUM_W  = SB + F + PB + 1;
   localparam int TOP_W  = NUM_W - SB;
   localparam int CNT_W  = $clog2(SB);
   localparam logic [NUM_W-1:0] WRAP_MASK =
      ~({NUM_W{1'b1}} << wrsi_pkg::NUM_WRAP_BITS);

   // --------------------------------------------------------------------
   // state
   // --------------------------------------------------------------------
   wrsi_pkg::state_type state_ff, state_in;
   logic                go_ff, go_in;        // first cycle in a state

   logic [PB-1:0]         period_ff, period_in;
   logic [PRICE_BITS-1:0] prev_ff, prev_in;
   logic                  have_prev_ff, have_prev_in;
   logic [SB-1:0]         gain_ff, gain_in;
   logic [SB-1:0]         loss_ff, loss_in;
   logic [PB-1:0]         count_ff, count_in;
   logic [PRICE_BITS-1:0] fresh_gain_ff, fresh_gain_in;
   logic [PRICE_BITS-1:0] fresh_loss_ff, fresh_loss_in;
   logic                  smooth_ff, smooth_in;   // 0: first average of sums
   logic [wrsi_pkg::RSI_BITS-1:0] rsi_ff, rsi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [wrsi_pkg::RSI_BITS-1:0] rsp_rsi_ff, rsp_rsi_in;

   // --------------------------------------------------------------------
   // datapath terms
   // --------------------------------------------------------------------
   logic                  csr_write;
   logic [PB-1:0]         p_eff;
   logic [PB-1:0]         count_inc;
   logic                  req_accept;
   logic                  restart;
   logic                  price_up;
   logic                  loss_phase;
   logic [SB-1:0]         store_sel;
   logic [PRICE_BITS-1:0] fresh_sel;
   logic [NUM_W-1:0]      num;
   logic [TOP_W-1:0]      num_top;
   logic                  avg_sat;
   logic                  loss_zero;
   logic                  rsp_load;

   // serial units
   logic                              mul_start;
   logic [SB-1:0]                     mul_a;
   logic [PB-1:0]                     mul_b;
   logic [wrsi_pkg::MUL_BITS-1:0]     mul_prod;
   wrsi_pkg::unit_status_type         mul_stat;

   logic                              div_start;
   logic [wrsi_pkg::REM_BITS-1:0]     div_rem_init;
   logic [SB-1:0]                     div_low_init;
   logic [wrsi_pkg::DEN_BITS-1:0]     div_den;
   logic [CNT_W-1:0]                  div_last_step;
   logic [SB-1:0]                     div_quot;
   wrsi_pkg::unit_status_type         div_stat;

   // APB: write on the access phase, no wait states
   assign csr_write  = csr_psel & csr_penable & csr_pwrite
                     & (csr_paddr == wrsi_pkg::CSR_PERIOD_ADDR);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == wrsi_pkg::CSR_PERIOD_ADDR)
                     ? wrsi_pkg::CSR_DATA_BITS'(period_ff) : '0;

   assign p_eff      = (period_ff == '0) ? PB'(1) : period_ff;
   assign count_inc  = count_ff + PB'(1);
   assign req_accept = req_ch.valid & req_ch.ready;
   assign restart    = req_ch.first_of_series | ~have_prev_ff;
   assign price_up   = req_ch.price > prev_ff;
   assign loss_zero  = (loss_ff == '0);

   assign loss_phase = (state_ff == wrsi_pkg::ST_MUL_LOSS)
                    || (state_ff == wrsi_pkg::ST_DIV_LOSS);
   assign store_sel  = loss_phase ? loss_ff : gain_ff;
   assign fresh_sel  = loss_phase ? fresh_loss_ff : fresh_gain_ff;

   // smoothing: (avg*(p-1) + fresh<<F) mod 2^64; first average: sum<<F
   assign num = smooth_ff
              ? ((NUM_W'(mul_prod) + (NUM_W'(fresh_sel) << F)) & WRAP_MASK)
              : (NUM_W'(store_sel) << F);
   assign num_top = num[NUM_W-1:SB];
   // quotient would not fit the store: clamp, no division needed
   assign avg_sat = num_top >= TOP_W'(p_eff);

   // multiplier operands: avg*(p-1) or gain*25 for the ratio
   assign mul_a = (state_ff == wrsi_pkg::ST_MUL_RSI) ? gain_ff : store_sel;
   assign mul_b = (state_ff == wrsi_pkg::ST_MUL_RSI) ? wrsi_pkg::RSI_SCALE
                                                      : (p_eff - PB'(1));

   // divider operands. Ratio: (gain*25 << 18) / (gain+loss); the quotient
   // is at most 100.0, so only its low RSI_BITS bits need to be developed.
   always_comb begin
      if (state_ff == wrsi_pkg::ST_DIV_RSI) begin
         div_rem_init  = wrsi_pkg::REM_BITS'(mul_prod >> wrsi_pkg::RSI_PRE_BITS);
         div_low_init  = {mul_prod[wrsi_pkg::RSI_PRE_BITS-1:0],
                          {(SB - wrsi_pkg::RSI_PRE_BITS){1'b0}}};
         div_den       = {1'b0, gain_ff} + {1'b0, loss_ff};
         div_last_step = CNT_W'(wrsi_pkg::RSI_BITS - 1);
      end else begin
         div_rem_init  = wrsi_pkg::REM_BITS'(num_top);
         div_low_init  = num[SB-1:0];
         div_den       = wrsi_pkg::DEN_BITS'(p_eff);
         div_last_step = CNT_W'(SB - 1);
      end
   end

   // --------------------------------------------------------------------
   // next state
   // --------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wrsi_pkg::ST_IDLE: begin
            if (req_accept && !restart) state_in = wrsi_pkg::ST_DIFF;
         end
         wrsi_pkg::ST_DIFF: begin
            if (count_ff == wrsi_pkg::WARM_MARK) begin
               state_in = wrsi_pkg::ST_MUL_GAIN;
            end else if (count_inc >= p_eff) begin
               state_in = wrsi_pkg::ST_DIV_GAIN;
            end else begin
               state_in = wrsi_pkg::ST_IDLE;
            end
         end
         wrsi_pkg::ST_MUL_GAIN: begin
            if (mul_stat.done) state_in = wrsi_pkg::ST_DIV_GAIN;
         end
         wrsi_pkg::ST_DIV_GAIN: begin
            if ((go_ff && avg_sat) || div_stat.done) begin
               state_in = smooth_ff ? wrsi_pkg::ST_MUL_LOSS : wrsi_pkg::ST_DIV_LOSS;
            end
         end
         wrsi_pkg::ST_MUL_LOSS: begin
            if (mul_stat.done) state_in = wrsi_pkg::ST_DIV_LOSS;
         end
         wrsi_pkg::ST_DIV_LOSS: begin
            if ((go_ff && avg_sat) || div_stat.done) state_in = wrsi_pkg::ST_MUL_RSI;
         end
         wrsi_pkg::ST_MUL_RSI: begin
            if (go_ff && loss_zero) begin
               state_in = wrsi_pkg::ST_EMIT;
            end else if (mul_stat.done) begin
               state_in = wrsi_pkg::ST_DIV_RSI;
            end
         end
         wrsi_pkg::ST_DIV_RSI: begin
            if (div_stat.done) state_in = wrsi_pkg::ST_EMIT;
         end
         wrsi_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = wrsi_pkg::ST_IDLE;
         end
         default: state_in = wrsi_pkg::ST_IDLE;
      endcase
   end

   assign go_in = (state_in != state_ff);

   // --------------------------------------------------------------------
   // FSM outputs
   // --------------------------------------------------------------------
   always_comb begin
      req_ch.ready = 1'b0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         wrsi_pkg::ST_IDLE:     req_ch.ready = 1'b1;
         wrsi_pkg::ST_MUL_GAIN,
         wrsi_pkg::ST_MUL_LOSS: mul_start = go_ff;
         wrsi_pkg::ST_MUL_RSI:  mul_start = go_ff & ~loss_zero;
         wrsi_pkg::ST_DIV_GAIN,
         wrsi_pkg::ST_DIV_LOSS: div_start = go_ff & ~avg_sat;
         wrsi_pkg::ST_DIV_RSI:  div_start = go_ff;
         wrsi_pkg::ST_EMIT:     rsp_load  = ~rsp_valid_ff | rsp_ch.ready;
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // --------------------------------------------------------------------
   // register next values
   // --------------------------------------------------------------------
   always_comb begin
      period_in     = csr_write ? csr_pwdata[PB-1:0] : period_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      gain_in       = gain_ff;
      loss_in       = loss_ff;
      count_in      = count_ff;
      fresh_gain_in = fresh_gain_ff;
      fresh_loss_in = fresh_loss_ff;
      smooth_in     = smooth_ff;
      rsi_in        = rsi_ff;
      case (state_ff)
         wrsi_pkg::ST_IDLE: begin
            if (req_accept) begin
               prev_in = req_ch.price;
               if (restart) begin
                  have_prev_in = 1'b1;
                  gain_in      = '0;
                  loss_in      = '0;
                  count_in     = '0;
               end else begin
                  // a flat price counts as a zero loss
                  fresh_gain_in = price_up ? (req_ch.price - prev_ff) : '0;
                  fresh_loss_in = price_up ? '0 : (prev_ff - req_ch.price);
               end
            end
         end
         wrsi_pkg::ST_DIFF: begin
            if (count_ff == wrsi_pkg::WARM_MARK) begin
               smooth_in = 1'b1;
            end else begin
               // warm-up sums wrap at the store width
               gain_in   = gain_ff + SB'(fresh_gain_ff);
               loss_in   = loss_ff + SB'(fresh_loss_ff);
               count_in  = (count_inc >= p_eff) ? wrsi_pkg::WARM_MARK : count_inc;
               smooth_in = 1'b0;
            end
         end
         wrsi_pkg::ST_DIV_GAIN: begin
            if (go_ff && avg_sat) begin
               gain_in = '1;
            end else if (div_stat.done) begin
               gain_in = div_quot;
            end
         end
         wrsi_pkg::ST_DIV_LOSS: begin
            if (go_ff && avg_sat) begin
               loss_in = '1;
            end else if (div_stat.done) begin
               loss_in = div_quot;
            end
         end
         wrsi_pkg::ST_MUL_RSI: begin
            if (go_ff && loss_zero) rsi_in = wrsi_pkg::RSI_FULL;
         end
         wrsi_pkg::ST_DIV_RSI: begin
            if (div_stat.done) rsi_in = div_quot[wrsi_pkg::RSI_BITS-1:0];
         end
         default: begin
            rsi_in = rsi_ff;
         end
      endcase
   end

   // output register: holds a result while the next transaction is accepted
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);
   assign rsp_rsi_in   = rsp_load ? rsi_ff : rsp_rsi_ff;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.rsi   = rsp_rsi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrsi_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         period_ff    <= wrsi_pkg::PERIOD_RESET;
         have_prev_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         period_ff    <= period_in;
         have_prev_ff <= have_prev_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_ff       <= prev_in;
      gain_ff       <= gain_in;
      loss_ff       <= loss_in;
      fresh_gain_ff <= fresh_gain_in;
      fresh_loss_ff <= fresh_loss_in;
      smooth_ff     <= smooth_in;
      rsi_ff        <= rsi_in;
      rsp_rsi_ff    <= rsp_rsi_in;
   end

   // --------------------------------------------------------------------
   // shared serial units
   // --------------------------------------------------------------------
   wrsi_serial_mul #(
      .A_BITS (SB),
      .B_BITS (PB)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .stat  (mul_stat)
   );

   wrsi_serial_div #(
      .LOW_BITS (SB),
      .DEN_BITS (wrsi_pkg::DEN_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .rem_init  (div_rem_init),
      .low_init  (div_low_init),
      .den       (div_den),
      .last_step (div_last_step),
      .quot      (div_quot),
      .stat      (div_stat)
   );

   // --------------------------------------------------------------------
   // checks
   // --------------------------------------------------------------------
   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_rsi_ff <= wrsi_pkg::RSI_FULL))
      else $error("RSI result above full scale");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == wrsi_pkg::ST_DIV_GAIN
                      || state_ff == wrsi_pkg::ST_DIV_LOSS
                      || state_ff == wrsi_pkg::ST_DIV_RSI))
      else $error("divider finished outside a divide state");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == wrsi_pkg::ST_MUL_GAIN
                      || state_ff == wrsi_pkg::ST_MUL_LOSS
                      || state_ff == wrsi_pkg::ST_MUL_RSI))
      else $error("multiplier finished outside a multiply state");

endmodule

/* rtl/core/wrsi_serial_mul.sv */
// ----------------------------------------------------------------------------
// wrsi_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module wrsi_serial_mul #(
   parameter int A_BITS = wrsi_pkg::STORE_BITS,
   parameter int B_BITS = wrsi_pkg::PERIOD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [A_BITS-1:0]             a,
   input  logic [B_BITS-1:0]             b,
   output logic [A_BITS+B_BITS-1:0]      prod,
   output wrsi_pkg::unit_status_type     stat
);

   localparam int P_BITS = A_BITS + B_BITS;
   localparam int CNT_W  = (B_BITS > 1) ? $clog2(B_BITS) : 1;

   logic [A_BITS-1:0] a_ff, a_in;
   logic [B_BITS-1:0] b_ff, b_in;
   logic [P_BITS-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[P_BITS-2:0], 1'b0}
                + (b_ff[B_BITS-1] ? P_BITS'(a_ff) : {P_BITS{1'b0}});
         b_in   = b_ff << 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(B_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign prod      = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/core/wrsi_serial_div.sv */
// ----------------------------------------------------------------------------
// wrsi_serial_div
// Restoring divider, one quotient bit per cycle. The caller preloads a
// partial remainder below the divisor and the low dividend bits to shift in.
// ----------------------------------------------------------------------------
module wrsi_serial_div #(
   parameter int LOW_BITS = wrsi_pkg::STORE_BITS,
   parameter int DEN_BITS = wrsi_pkg::DEN_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [DEN_BITS:0]                rem_init,
   input  logic [LOW_BITS-1:0]              low_init,
   input  logic [DEN_BITS-1:0]              den,
   input  logic [$clog2(LOW_BITS)-1:0]      last_step,
   output logic [LOW_BITS-1:0]              quot,
   output wrsi_pkg::unit_status_type        stat
);

   localparam int REM_BITS = DEN_BITS + 1;
   localparam int CNT_W    = $clog2(LOW_BITS);

   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [LOW_BITS-1:0] low_ff, low_in;
   logic [LOW_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [REM_BITS-1:0] rem_shift;
   logic                fits;

   assign rem_shift = {rem_ff[REM_BITS-2:0], low_ff[LOW_BITS-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         low_in  = low_init;
         quot_in = '0;
         den_in  = den;
         cnt_in  = last_step;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_shift - {1'b0, den_ff}) : rem_shift;
         low_in  = {low_ff[LOW_BITS-2:0], 1'b0};
         quot_in = {quot_ff[LOW_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   // partial remainder must stay below the divisor or the quotient is wrong
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < {1'b0, den_ff}))
      else $error("divider remainder not below divisor");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the Wilder RSI block.
// ----------------------------------------------------------------------------
// Drives price transactions through the request channel, predicts each RSI
// transaction in a local model of the warm-up sums, the smoothed averages
// and the ratio, and checks the response channel in order. The period
// register is programmed over APB between phases, only while the block is
// idle. Directed cases come first, then random price walks under several
// idle and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRICE_BITS    = wrsi_pkg::PRICE_BITS_DEF;
   localparam int AVG_FRAC      = wrsi_pkg::AVG_FRAC_BITS_DEF;
   localparam int PERIOD_BITS   = wrsi_pkg::PERIOD_BITS;
   localparam int RSI_BITS      = wrsi_pkg::RSI_BITS;
   localparam int CSR_ADDR_BITS = wrsi_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = wrsi_pkg::CSR_DATA_BITS;
   localparam logic [63:0] STORE_MAX = (64'd1 << wrsi_pkg::STORE_BITS) - 64'd1;

   // leave margin for a warm item to finish before touching the CSR
   localparam int DRAIN_CYCLES = 250;
   // cycles without any transaction before the run is declared hung
   localparam int QUIET_LIMIT  = 5000;

   logic clock = 1'b0;
   logic reset;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   wrsi_req_if #(.PRICE_BITS(PRICE_BITS)) req_bus ();
   wrsi_rsp_if                            rsp_bus ();

   wilder_relative_strength_index #(
      .PRICE_BITS            (PRICE_BITS),
      .AVERAGE_FRACTION_BITS (AVG_FRAC)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus.sink),
      .rsp_ch      (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Local model of the indicator state
   // ---------------------------------------------------------------------
   logic [PERIOD_BITS-1:0] model_period;
   logic [PRICE_BITS-1:0]  model_prev_price;
   bit                     model_have_prev;
   logic [63:0]            model_gain_avg;   // sum during warm-up, average after
   logic [63:0]            model_loss_avg;
   logic [PERIOD_BITS-1:0] model_diff_count; // WARM_MARK once averages are warm

   logic [RSI_BITS-1:0] expected_rsi_q[$];

   int error_count  = 0;
   int quiet_cycles = 0;
   int tx_idle_pct  = 0;   // chance the price sender idles a cycle
   int rx_stall_pct = 0;   // chance the RSI receiver stalls a cycle

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("%0t ERROR %s: expected %0d, got %0d", $time, what, want, got);
      error_count++;
   endtask

   // First average: sum / period with AVG_FRAC extra fraction bits, saturating.
   function automatic logic [63:0] seed_average(input logic [63:0] sum,
                                                input logic [63:0] p);
      logic [63:0] whole;
      logic [63:0] rem;
      logic [63:0] avg;
      whole = sum / p;
      rem   = sum % p;
      if (whole > (STORE_MAX >> AVG_FRAC))
         return STORE_MAX;
      avg = (whole << AVG_FRAC) + ((rem << AVG_FRAC) / p);
      return (avg > STORE_MAX) ? STORE_MAX : avg;
   endfunction

   // Wilder smoothing step, truncating, saturating at the store maximum.
   function automatic logic [63:0] wilder_smooth(input logic [63:0] avg,
                                                 input logic [63:0] fresh,
                                                 input logic [63:0] p);
      logic [63:0] acc;
      acc = avg * (p - 64'd1) + (fresh << AVG_FRAC);
      acc = acc / p;
      return (acc > STORE_MAX) ? STORE_MAX : acc;
   endfunction

   // 100 * gain / (gain + loss) in Q7.16; full scale when there is no loss.
   function automatic logic [RSI_BITS-1:0] rsi_ratio(input logic [63:0] g,
                                                     input logic [63:0] l);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      if (l == 64'd0)
         return wrsi_pkg::RSI_FULL;
      num = {64'd0, g} * 128'(wrsi_pkg::RSI_FULL);
      den = {64'd0, g} + {64'd0, l};
      quo = num / den;
      if (quo > 128'(wrsi_pkg::RSI_FULL))
         quo = 128'(wrsi_pkg::RSI_FULL);
      return quo[RSI_BITS-1:0];
   endfunction

   // Advance the model by one price; returns 1 when an RSI comes out.
   function automatic bit predict_rsi(input logic [PRICE_BITS-1:0] price,
                                      input bit first,
                                      output logic [RSI_BITS-1:0] rsi);
      logic [63:0] p;
      logic [63:0] gain;
      logic [63:0] loss;
      p    = (model_period == '0) ? 64'd1 : 64'(model_period);
      gain = 64'd0;
      loss = 64'd0;
      rsi  = '0;

      // restart, or nothing to difference against yet
      if (first || !model_have_prev) begin
         model_prev_price = price;
         model_have_prev  = 1'b1;
         model_gain_avg   = 64'd0;
         model_loss_avg   = 64'd0;
         model_diff_count = '0;
         return 1'b0;
      end

      // a flat price counts as a zero loss
      if (price > model_prev_price)
         gain = 64'(price - model_prev_price);
      else
         loss = 64'(model_prev_price - price);
      model_prev_price = price;

      if (model_diff_count != wrsi_pkg::WARM_MARK) begin
         model_gain_avg   = (model_gain_avg + gain) & STORE_MAX;
         model_loss_avg   = (model_loss_avg + loss) & STORE_MAX;
         model_diff_count = model_diff_count + PERIOD_BITS'(1);
         // warm-up ends once the count reaches the period in force now
         if (64'(model_diff_count) < p)
            return 1'b0;
         model_gain_avg   = seed_average(model_gain_avg, p);
         model_loss_avg   = seed_average(model_loss_avg, p);
         model_diff_count = wrsi_pkg::WARM_MARK;
      end else begin
         model_gain_avg = wilder_smooth(model_gain_avg, gain, p);
         model_loss_avg = wilder_smooth(model_loss_avg, loss, p);
      end

      rsi = rsi_ratio(model_gain_avg, model_loss_avg);
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random backpressure, in-order check of each RSI
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_bus.ready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
   end

   always @(posedge clock) begin : rsi_monitor
      logic [RSI_BITS-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsi_q.size() == 0) begin
            report_mismatch("rsi transaction with none pending", 0, rsp_bus.rsi);
         end else begin
            want = expected_rsi_q.pop_front();
            if (rsp_bus.rsi !== want)
               report_mismatch("rsi", want, rsp_bus.rsi);
         end
      end
   end

   // Hang detector: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ERROR no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Called just after a rising edge; returns at the edge of acceptance.
   task automatic send_price(input logic [PRICE_BITS-1:0] price, input bit first);
      logic [RSI_BITS-1:0] rsi;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.price           <= price;
      req_bus.first_of_series <= first;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (predict_rsi(price, first, rsi))
         expected_rsi_q.push_back(rsi);
   endtask

   // Block idle: all RSI transactions back, and time for a result-less item
   // still in flight to retire.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_rsi_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // APB access
   // ---------------------------------------------------------------------
   task automatic check_period_reg();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= wrsi_pkg::CSR_PERIOD_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(model_period))
         report_mismatch("period readback", model_period, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_period(input logic [PERIOD_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= wrsi_pkg::CSR_PERIOD_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      model_period = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      check_period_reg();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_period_reset_value();
      check_period_reg();
   endtask

   // Largest gain, largest loss, flat prices, no-loss ratios,
   // start without a previous price, restart in the middle of a series.
   task automatic test_price_extremes();
      program_period(8'd2);
      send_price(32'h0000_0000, 1'b0);   // no previous price yet: seed only
      send_price(32'hFFFF_FFFF, 1'b0);   // full-scale gain
      send_price(32'h0000_0000, 1'b0);   // full-scale loss, warm-up ends
      send_price(32'h0000_0000, 1'b0);   // flat
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h1234_5678, 1'b1);   // restart mid-series
      send_price(32'h1234_5678, 1'b0);
      send_price(32'h1234_5678, 1'b0);   // both averages zero -> full scale
      send_price(32'h1234_5679, 1'b0);
      drain_results();
   endtask

   // A period of zero behaves as one: every difference yields an RSI.
   task automatic test_period_zero();
      program_period(8'd0);
      send_price(32'd100, 1'b1);
      send_price(32'd50, 1'b0);          // pure loss -> zero
      send_price(32'h8000_0000, 1'b0);
      drain_results();
   endtask

   // Shrink the period below the count in mid warm-up: the averages are
   // taken with the new period and saturate.
   task automatic test_period_change_in_warmup();
      program_period(8'd5);
      send_price(32'h0000_0000, 1'b1);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h0000_0000, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h0000_0000, 1'b0);
      drain_results();
      program_period(8'd1);
      send_price(32'hFFFF_FFFF, 1'b0);
      drain_results();
   endtask

   // Once warm, a new period just changes the smoothing weight.
   task automatic test_period_change_when_warm();
      program_period(8'd3);
      send_price(32'd5000, 1'b0);
      send_price(32'd6000, 1'b0);
      drain_results();
      program_period(8'd255);
      send_price(32'd5500, 1'b0);
      send_price(32'd7000, 1'b0);
      drain_results();
   endtask

   // Random walk: mostly small moves of random size, some flat prices,
   // some jumps to a fully random price.
   function automatic logic [PRICE_BITS-1:0] walk_price(input logic [PRICE_BITS-1:0] last);
      logic [63:0] step;
      int          sel;
      sel = $urandom_range(15);
      if (sel == 0)
         return $urandom;
      if (sel <= 2)
         return last;
      step = 64'($urandom) & ((64'd1 << $urandom_range(1, 32)) - 64'd1);
      if ($urandom_range(1))
         return last + PRICE_BITS'(step);
      return last - PRICE_BITS'(step);
   endfunction

   task automatic test_random_stream(input int count, input logic [PERIOD_BITS-1:0] period,
                                     input int restart_pct, input int tx_pct, input int rx_pct);
      logic [PRICE_BITS-1:0] price;
      bit                    first;
      program_period(period);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      price = $urandom;
      send_price(price, 1'b1);
      for (int i = 1; i < count; i++) begin
         first = ($urandom_range(99) < restart_pct);
         price = walk_price(price);
         send_price(price, first);
      end
      drain_results();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.price           <= '0;
      req_bus.first_of_series <= 1'b0;
      csr_psel                <= 1'b0;
      csr_penable             <= 1'b0;
      csr_pwrite              <= 1'b0;
      csr_paddr               <= '0;
      csr_pwdata              <= '0;

      // model state after reset
      model_period     = wrsi_pkg::PERIOD_RESET;
      model_prev_price = '0;
      model_have_prev  = 1'b0;
      model_gain_avg   = 64'd0;
      model_loss_avg   = 64'd0;
      model_diff_count = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_period_reset_value();
      test_price_extremes();
      test_period_zero();
      test_period_change_in_warmup();
      test_period_change_when_warm();

      // no idling
      test_random_stream(150, 8'd1, 3, 0, 0);
      test_random_stream(200, 8'($urandom_range(2, 16)), 2, 0, 0);
      // sender mostly idle
      test_random_stream(250, 8'($urandom_range(2, 30)), 1, 82, 0);
      test_random_stream(100, 8'd0, 3, 82, 0);
      // receiver mostly stalled; longest period without restarts
      test_random_stream(300, 8'd255, 0, 0, 82);
      test_random_stream(200, 8'($urandom_range(2, 8)), 2, 0, 82);
      // both sides idling now and then
      test_random_stream(250, 8'($urandom_range(1, 20)), 2, 23, 23);
      test_random_stream(150, wrsi_pkg::PERIOD_RESET, 1, 23, 23);

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
